/* rtl/core/srm_pkg.sv */
// ----------------------------------------------------------------------------
// srm_pkg
// Shared types and constants for the sorted range map.
// ----------------------------------------------------------------------------
`default_nettype none
package srm_pkg;

  localparam int MAX_ENTRIES_DEF = 128;

  // Item kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADIDX = 2'd2;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] len;
    logic [31:0] typ;
  } entry_t;

  // Flags and sums from the shared compare/add unit
  typedef struct packed {
    logic [63:0] e_end;
    logic        start_gt_eend;
    logic        start_gt_base;
    logic        end_lt_base;
    logic        end_ge_eend;
    logic        eend_gt_end;
    logic [63:0] head_len;
    logic [63:0] tail_len;
    logic [63:0] head_size;
    logic [63:0] tail_size;
  } unit_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_EV,
    S_B_RD,
    S_B_EV,
    S_INS_CHK,
    S_INS_LOOP,
    S_INS_WR,
    S_DEL_LOOP,
    S_DEL_WR,
    S_FINAL,
    S_READ_RD,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

/* rtl/core/sorted_range_map_add_remove.sv */
// ----------------------------------------------------------------------------
// sorted_range_map_add_remove
// Sorted table of typed, non-overlapping ranges with add, remove and read.
// Reads, zero-size items and the unused kind skip the scan. Add and remove
// scan the entries in order and shift the tail of the table on each insert
// or delete; each removed entry shifts the tail.
// One item at a time; the next is taken while a result waits for pickup.
// Reset (synchronous, active high) empties the table; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_range_map_add_remove #(
  parameter int MAX_ENTRIES = srm_pkg::MAX_ENTRIES_DEF,
  parameter int AW          = $clog2(MAX_ENTRIES),
  parameter int CW          = $clog2(MAX_ENTRIES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    kind,
  input  wire logic [63:0]   range_start,
  input  wire logic [63:0]   range_size,
  input  wire logic [31:0]   range_type,
  input  wire logic [6:0]    read_index,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [63:0]        entry_base,
  output logic [63:0]        entry_length,
  output logic [31:0]        entry_type,
  output logic [CW-1:0]      entry_count,
  output logic [1:0]         status
);
  import srm_pkg::*;

  state_t      state, state_next;
  state_t      ret;
  logic [1:0]  kind_r;
  logic [63:0] start_r, size_r, end_r;
  logic [31:0] type_r;
  logic [6:0]  idx_r;
  logic        is_hole, dropped;
  logic [CW-1:0] count, i, j;
  entry_t      ins_ent;

  entry_t      rdata, wdata;
  logic        wen;
  logic [CW-1:0] waddr, raddr;
  unit_res_t   ur;

  logic        in_acc, out_free, type_eq, i_lt_cnt, idx_ok, full;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = rst || (state != S_IDLE);
  assign type_eq  = !is_hole && (type_r == rdata.typ);
  assign i_lt_cnt = i < count;
  assign idx_ok   = 32'(idx_r) < 32'(count);
  assign full     = 32'(count) >= MAX_ENTRIES;

  srm_table #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_table (
    .clk   (clk),
    .wen   (wen),
    .waddr (waddr[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr[AW-1:0]),
    .rdata (rdata)
  );

  srm_unit u_unit (
    .ent       (rdata),
    .start     (start_r),
    .stop_addr (end_r),
    .size      (size_r),
    .res       (ur)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (kind == KIND_READ) state_next = S_READ_RD;
          else if ((kind == KIND_ADD || kind == KIND_REMOVE) && range_size != '0)
            state_next = S_A_RD;
          else state_next = S_DONE;
        end
      end
      S_A_RD:  state_next = i_lt_cnt ? S_A_EV : S_B_RD;
      S_A_EV: begin
        if (ur.start_gt_eend) state_next = S_A_RD;
        else if (ur.start_gt_base && !type_eq && ur.eend_gt_end) state_next = S_INS_CHK;
        else state_next = S_B_RD;
      end
      S_B_RD:  state_next = i_lt_cnt ? S_B_EV : S_FINAL;
      S_B_EV: begin
        if (ur.end_lt_base) state_next = S_FINAL;
        else if (ur.end_ge_eend || type_eq) state_next = S_DEL_LOOP;
        else state_next = S_FINAL;
      end
      S_INS_CHK:  state_next = full ? ret : S_INS_LOOP;
      S_INS_LOOP: state_next = (j > i) ? S_INS_WR : ret;
      S_INS_WR:   state_next = S_INS_LOOP;
      S_DEL_LOOP: state_next = ((j + CW'(1)) <= count) && (j < count) ? S_DEL_WR : ret;
      S_DEL_WR:   state_next = S_DEL_LOOP;
      S_FINAL:    state_next = is_hole ? S_DONE : S_INS_CHK;
      S_READ_RD:  state_next = S_DONE;
      S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Store port controls
  always_comb begin
    wen   = 1'b0;
    waddr = i;
    wdata = rdata;
    raddr = CW'(AW'(idx_r));
    unique case (state)
      S_A_RD, S_B_RD: raddr = i;
      S_A_EV: begin
        if (!ur.start_gt_eend && ur.start_gt_base && !type_eq) begin
          wen      = 1'b1;
          wdata    = rdata;
          wdata.len = ur.head_len;
        end
      end
      S_B_EV: begin
        if (!ur.end_lt_base && !ur.end_ge_eend && !type_eq) begin
          wen   = 1'b1;
          wdata = '{base: end_r, len: ur.tail_len, typ: rdata.typ};
        end
      end
      S_INS_LOOP: begin
        raddr = j - CW'(1);
        if (!(j > i)) begin
          wen   = 1'b1;
          wdata = ins_ent;
        end
      end
      S_INS_WR: begin
        wen   = 1'b1;
        waddr = j;
      end
      S_DEL_LOOP: raddr = j + CW'(1);
      S_DEL_WR: begin
        wen   = 1'b1;
        waddr = j;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      dropped   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE:     if (in_acc) dropped <= 1'b0;
        S_B_EV: begin
          if (!ur.end_lt_base && (ur.end_ge_eend || type_eq)) count <= count - CW'(1);
        end
        S_INS_CHK:  if (full) dropped <= 1'b1;
        S_INS_LOOP: if (!(j > i)) count <= count + CW'(1);
        S_DONE:     if (out_free) out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // Working registers and result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          kind_r  <= kind;
          start_r <= range_start;
          size_r  <= range_size;
          end_r   <= range_start + range_size;
          type_r  <= range_type;
          idx_r   <= read_index;
          is_hole <= (kind == KIND_REMOVE);
          i       <= '0;
        end
      end
      S_A_EV: begin
        if (ur.start_gt_eend) begin
          i <= i + CW'(1);
        end else if (ur.start_gt_base) begin
          if (type_eq) begin
            size_r  <= ur.head_size;
            start_r <= rdata.base;
          end else begin
            i       <= i + CW'(1);
            ins_ent <= '{base: end_r, len: ur.tail_len, typ: rdata.typ};
            ret     <= S_B_RD;
          end
        end
      end
      S_B_EV: begin
        if (!ur.end_lt_base) begin
          j <= i;
          if (ur.end_ge_eend) begin
            ret <= S_B_RD;
          end else if (type_eq) begin
            size_r <= ur.tail_size;
            ret    <= S_FINAL;
          end
        end
      end
      S_INS_CHK:  j <= count;
      S_INS_WR:   j <= j - CW'(1);
      S_DEL_WR:   j <= j + CW'(1);
      S_FINAL: begin
        ins_ent <= '{base: start_r, len: size_r, typ: type_r};
        ret     <= S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          entry_count <= count;
          if (kind_r == KIND_READ && idx_ok) begin
            entry_base   <= rdata.base;
            entry_length <= rdata.len;
            entry_type   <= rdata.typ;
            status       <= ST_OK;
          end else begin
            entry_base   <= '0;
            entry_length <= '0;
            entry_type   <= '0;
            if (kind_r == KIND_READ) status <= ST_BADIDX;
            else status <= dropped ? ST_FULL : ST_OK;
          end
        end
      end
      default: ;
    endcase
  end

  // Checks
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= MAX_ENTRIES)
    else $error("entry count above table depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) || count == $past(count) + CW'(1) ||
                     count == $past(count) - CW'(1)))
    else $error("entry count moved by more than one");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    wen |-> 32'(waddr) < MAX_ENTRIES)
    else $error("store write beyond table depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state != S_IDLE)
    else $error("accepted item left no work");

endmodule
`default_nettype wire

/* rtl/core/srm_table.sv */
// ----------------------------------------------------------------------------
// srm_table
// Entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module srm_table #(
  parameter int DEPTH = srm_pkg::MAX_ENTRIES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            wen,
  input  wire logic [AW-1:0]   waddr,
  input  wire srm_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output srm_pkg::entry_t      rdata
);
  import srm_pkg::*;

  entry_t mem [DEPTH];

  // Write and read the store
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/srm_unit.sv */
// ----------------------------------------------------------------------------
// srm_unit
// Shared compare/add unit: relates one stored entry to the range at work.
// ----------------------------------------------------------------------------
`default_nettype none
module srm_unit (
  input  wire srm_pkg::entry_t ent,
  input  wire logic [63:0]     start,
  input  wire logic [63:0]     stop_addr,
  input  wire logic [63:0]     size,
  output srm_pkg::unit_res_t   res
);
  import srm_pkg::*;

  logic [63:0] e_end;

  // End of the stored entry, modulo 2^64
  assign e_end = ent.base + ent.len;

  // Compare and derive trimmed lengths and merged sizes
  always_comb begin
    res.e_end         = e_end;
    res.start_gt_eend = start > e_end;
    res.start_gt_base = start > ent.base;
    res.end_lt_base   = stop_addr < ent.base;
    res.end_ge_eend   = stop_addr >= e_end;
    res.eend_gt_end   = e_end > stop_addr;
    res.head_len      = start - ent.base;
    res.tail_len      = e_end - stop_addr;
    res.head_size     = size + start - ent.base;
    res.tail_size     = size + e_end - stop_addr;
  end

endmodule
`default_nettype wire

/* tb/sv/srm_checker.sv */
// ----------------------------------------------------------------------------
// srm_checker
// Watches both channels of the sorted range map, keeps its own copy of the
// range table, predicts one result per accepted item and compares in order.
// ----------------------------------------------------------------------------
module srm_checker
  import srm_pkg::*;
#(
  parameter int DEPTH = 128,
  parameter int CW    = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_stall,
  input  logic [1:0]    kind,
  input  logic [63:0]   range_start,
  input  logic [63:0]   range_size,
  input  logic [31:0]   range_type,
  input  logic [6:0]    read_index,
  input  logic          out_valid,
  input  logic          out_stall,
  input  logic [63:0]   entry_base,
  input  logic [63:0]   entry_length,
  input  logic [31:0]   entry_type,
  input  logic [CW-1:0] entry_count,
  input  logic [1:0]    status,
  output int            fail_count,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0] base;
    logic [63:0] len;
    logic [31:0] typ;
    int          count;
    logic [1:0]  st;
  } map_result_t;

  entry_t      map_tbl[DEPTH];
  int          map_count;
  map_result_t results_due[$];

  function automatic bit tbl_insert(int pos, logic [63:0] b, logic [63:0] l,
                                    logic [31:0] t);
    if (map_count >= DEPTH) return 0;
    if (pos > map_count) pos = map_count;
    for (int k = map_count; k > pos; k--) map_tbl[k] = map_tbl[k-1];
    map_tbl[pos] = '{base: b, len: l, typ: t};
    map_count++;
    return 1;
  endfunction

  function automatic void tbl_delete(int pos);
    if (pos >= map_count) return;
    map_count--;
    for (int k = pos; k < map_count; k++) map_tbl[k] = map_tbl[k+1];
  endfunction

  // Carve [start, start+size) out of the table; insert it unless a hole.
  // Key is the type widened to 33 bits; bit 32 set marks a hole.
  function automatic bit carve_range(logic [63:0] start, logic [63:0] size,
                                     logic [32:0] key);
    logic [63:0] stop, e_end;
    bit          dropped;
    int          i;
    dropped = 0;
    if (size == 0) return 0;
    stop = start + size;
    for (i = 0; i < map_count; i++) begin
      e_end = map_tbl[i].base + map_tbl[i].len;
      if (start > e_end) continue;
      if (start > map_tbl[i].base) begin
        if (key == {1'b0, map_tbl[i].typ}) begin
          size  = size + (start - map_tbl[i].base);
          start = map_tbl[i].base;
        end else begin
          map_tbl[i].len = start - map_tbl[i].base;
          i++;
          if (e_end > stop && !tbl_insert(i, stop, e_end - stop, map_tbl[i-1].typ))
            dropped = 1;
        end
      end
      break;
    end
    while (i < map_count) begin
      if (stop < map_tbl[i].base) break;
      e_end = map_tbl[i].base + map_tbl[i].len;
      if (stop >= e_end) begin
        tbl_delete(i);
        continue;
      end
      map_tbl[i].base = stop;
      map_tbl[i].len  = e_end - stop;
      if (key == {1'b0, map_tbl[i].typ}) begin
        size = size + map_tbl[i].len;
        tbl_delete(i);
      end
      break;
    end
    if (!key[32] && !tbl_insert(i, start, size, key[31:0])) dropped = 1;
    return dropped;
  endfunction

  // Predict on each accepted item, compare on each accepted result.
  always @(posedge clk) begin
    map_result_t r, got;
    int          errs;
    errs = 0;
    if (rst) begin
      map_count = 0;
      results_due.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{entry_base, entry_length, entry_type, int'(entry_count), status};
        if (results_due.size() == 0) begin
          $error("result with no item outstanding");
          errs++;
        end else begin
          r = results_due.pop_front();
          if (got.base !== r.base) begin
            $error("entry_base exp %h got %h", r.base, got.base);
            errs++;
          end
          if (got.len !== r.len) begin
            $error("entry_length exp %h got %h", r.len, got.len);
            errs++;
          end
          if (got.typ !== r.typ) begin
            $error("entry_type exp %h got %h", r.typ, got.typ);
            errs++;
          end
          if (got.count != r.count || $isunknown(entry_count)) begin
            $error("entry_count exp %0d got %0d", r.count, entry_count);
            errs++;
          end
          if (got.st !== r.st) begin
            $error("status exp %0d got %0d", r.st, got.st);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        r = '{64'd0, 64'd0, 32'd0, 0, ST_OK};
        if (kind == KIND_ADD) begin
          if (carve_range(range_start, range_size, {1'b0, range_type})) r.st = ST_FULL;
        end else if (kind == KIND_REMOVE) begin
          if (carve_range(range_start, range_size, {1'b1, 32'd0})) r.st = ST_FULL;
        end else if (kind == KIND_READ) begin
          if (int'(read_index) < map_count) begin
            r.base = map_tbl[read_index].base;
            r.len  = map_tbl[read_index].len;
            r.typ  = map_tbl[read_index].typ;
          end else begin
            r.st = ST_BADIDX;
          end
        end
        r.count = map_count;
        results_due.push_back(r);
      end
      pending <= results_due.size();
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end
endmodule

/* tb/sv/tb_sorted_range_map_add_remove.sv */
// ----------------------------------------------------------------------------
// tb_sorted_range_map_add_remove
// Drives directed and random add, remove and read items into the range map
// under varying backpressure; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_sorted_range_map_add_remove;
  import srm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 128;
  localparam int CW    = $clog2(DEPTH + 1);

  logic          clk = 0;
  logic          rst = 1;
  logic          in_valid = 0;
  logic          in_stall;
  logic [1:0]    kind = KIND_READ;
  logic [63:0]   range_start = '0;
  logic [63:0]   range_size = '0;
  logic [31:0]   range_type = '0;
  logic [6:0]    read_index = '0;
  logic          out_valid;
  logic          out_stall = 0;
  logic [63:0]   entry_base, entry_length;
  logic [31:0]   entry_type;
  logic [CW-1:0] entry_count;
  logic [1:0]    status;
  int            fail_count, pending;
  int            send_idle_pct = 0, recv_idle_pct = 0;
  bit            hold_off = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  sorted_range_map_add_remove #(.MAX_ENTRIES(DEPTH)) uut (.*);

  srm_checker #(.DEPTH(DEPTH), .CW(CW)) chk (.*);

  // Receiver stall: random, or solid during a hold-off.
  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // Offer one item, idle at random first, hold until accepted.
  task automatic send_item(logic [1:0] k, logic [63:0] s, logic [63:0] z,
                           logic [31:0] t, logic [6:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid    <= 1;
    kind        <= k;
    range_start <= s;
    range_size  <= z;
    range_type  <= t;
    read_index  <= idx;
    do @(posedge clk); while (in_stall);
  endtask

  // Mostly small, clustered addresses so ranges touch, overlap and split.
  task automatic send_random();
    logic [63:0] s, z;
    logic [1:0]  k;
    int          r;
    r = $urandom_range(99);
    k = (r < 50) ? KIND_ADD : (r < 75) ? KIND_REMOVE : (r < 97) ? KIND_READ : KIND_UNUSED;
    s = 64'($urandom_range(4000));
    z = 64'($urandom_range(1, 200));
    case ($urandom_range(19))
      0: s = {$urandom, $urandom};
      1: z = {$urandom, $urandom};
      2: z = '0;
      3: s = 64'hFFFF_FFFF_FFFF_FF00 + 64'($urandom_range(255));
      default: ;
    endcase
    send_item(k, s, z, ($urandom_range(9) == 0) ? $urandom : $urandom_range(3),
              7'($urandom_range(127)));
  endtask

  // Drop valid, then wait for every outstanding result.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  initial begin
    #200_000_000;
    $display("tb_sorted_range_map_add_remove NOT OK");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty reads, zero sizes, extremes, merges, splits, holes, wrap.
    send_item(KIND_READ, 0, 0, 0, 0);
    send_item(KIND_ADD, 64'd100, 64'd0, 32'd1, 0);
    send_item(KIND_REMOVE, 64'd100, 64'd0, 0, 0);
    send_item(KIND_ADD, 64'd1000, 64'd100, 32'd1, 0);
    send_item(KIND_ADD, 64'd1100, 64'd50, 32'd1, 0);
    send_item(KIND_ADD, 64'd900, 64'd100, 32'd1, 0);
    send_item(KIND_ADD, 64'd1020, 64'd10, 32'd2, 0);
    send_item(KIND_REMOVE, 64'd950, 64'd20, 0, 0);
    send_item(KIND_ADD, 64'd0, 64'd5000, 32'hFFFF_FFFF, 0);
    send_item(KIND_ADD, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20, 32'h7, 0);
    send_item(KIND_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h5, 0);
    send_item(KIND_READ, 0, 0, 0, 0);
    send_item(KIND_READ, 0, 0, 0, 1);
    send_item(KIND_READ, 0, 0, 0, 7'd127);
    send_item(KIND_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              32'hFFFF_FFFF, 7'h7F);
    send_item(KIND_REMOVE, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
    // Fill the table with disjoint ranges, then split one to hit the full case.
    for (int n = 0; n < DEPTH; n++)
      send_item(KIND_ADD, n * 64'd10, 64'd4, 32'(n[0]), 0);
    send_item(KIND_ADD, 64'd12, 64'd1, 32'd9, 0);
    send_item(KIND_ADD, 64'd1, 64'd1, 32'd9, 0);
    send_item(KIND_READ, 0, 0, 0, 7'd127);
    send_item(KIND_REMOVE, 64'd0, 64'd10000, 0, 0);

    // Random phases under three idle settings, with a hold-off in the first.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 76 : 0;
      recv_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 13 : 0;
      for (int n = 0; n < 490; n++) begin
        if (ph == 0 && n == 100) begin
          fork
            begin
              hold_off = 1;
              repeat (2000) @(posedge clk);
              hold_off = 0;
            end
          join_none
        end
        send_random();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("tb_sorted_range_map_add_remove OK");
    end else begin
      $display("tb_sorted_range_map_add_remove NOT OK");
    end
    $finish;
  end
endmodule

/* sorted_range_map_add_remove.f */
rtl/core/srm_pkg.sv
rtl/core/srm_table.sv
rtl/core/srm_unit.sv
rtl/core/sorted_range_map_add_remove.sv
tb/sv/srm_checker.sv
tb/sv/tb_sorted_range_map_add_remove.sv
